// ===== rtl/pida_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the positional insert/delete array
// no dependencies

package pida_pkg;

  localparam int unsigned DefCapacity = 16;

  localparam int unsigned ReqW    = 2;
  localparam int unsigned PlaceW  = 2;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqW-1:0] REQ_DELETE = 2'd1;
  localparam logic [ReqW-1:0] REQ_READ   = 2'd2;

  localparam logic [PlaceW-1:0] PLACE_START = 2'd0;
  localparam logic [PlaceW-1:0] PLACE_END   = 2'd1;
  localparam logic [PlaceW-1:0] PLACE_POS   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_BADPOS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY  = 2'd3;

  // command from controller to datapath
  typedef struct packed {
    logic exec;
  } pida_cmd_t;

endpackage

// ===== rtl/positional_insert_delete_array.sv =====
`timescale 1ns / 1ps
// top level of the positional insert/delete array
// depends on pida_pkg, pida_ctrl and pida_datapath

// Keeps a dense ordered array of up to CAPACITY signed 32-bit entries.
// Input channel (in_valid_i / in_stall_o): one request per transaction,
// req_type_i insert, delete or read, place_i start, end or given position,
// position_i 1-based, value_i the value to insert.
// Output channel (out_valid_o / out_stall_i): one result per request with
// status_o, count_after_o and read_value_o (zero unless a read succeeds).
// The request is decoded, the entry cells shift and the result register
// loads at the edge that accepts it, and the result is valid from the next
// cycle. Throughput is one request per cycle while out_stall_i is low;
// the entry cells each take their own value, a neighbor's or the new
// value at that edge, with the read mux over the cells in the same cycle.
// While a result is held and out_stall_i is high, in_stall_o is high; a new
// request is accepted in the same cycle that the held result is taken.
// Reset clears the entry count and the output valid; entry contents are
// not cleared and are never read before they are written.

module positional_insert_delete_array #(
  parameter int unsigned CAPACITY = pida_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pida_pkg::ReqW-1:0]            req_type_i,
  input  logic [pida_pkg::PlaceW-1:0]          place_i,
  input  logic [pida_pkg::PosW-1:0]            position_i,
  input  logic signed [pida_pkg::ValueW-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [pida_pkg::StatusW-1:0]         status_o,
  output logic [pida_pkg::CountW-1:0]          count_after_o,
  output logic signed [pida_pkg::ValueW-1:0]   read_value_o
);
  import pida_pkg::*;

  pida_cmd_t cmd;

  pida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pida_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .place_i       (place_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .count_after_o (count_after_o),
    .read_value_o  (read_value_o)
  );

endmodule

// ===== rtl/pida_ctrl.sv =====
`timescale 1ns / 1ps
// handshake controller: accepts a transaction and holds the result until taken
// depends on pida_pkg

module pida_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pida_pkg::pida_cmd_t cmd_o
);
  import pida_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   exec;

  // a new transaction may enter while the held result leaves
  assign in_stall_o  = (state_q == S_HOLD) && out_stall_i;
  assign exec        = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_HOLD);
  assign cmd_o.exec  = exec;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (exec) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall_i && !exec) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pida_datapath.sv =====
`timescale 1ns / 1ps
// row of shifting entry cells, entry count and result register
// depends on pida_pkg

module pida_datapath #(
  parameter int unsigned CAPACITY = pida_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pida_pkg::pida_cmd_t                  cmd_i,
  input  logic [pida_pkg::ReqW-1:0]            req_type_i,
  input  logic [pida_pkg::PlaceW-1:0]          place_i,
  input  logic [pida_pkg::PosW-1:0]            position_i,
  input  logic signed [pida_pkg::ValueW-1:0]   value_i,
  output logic [pida_pkg::StatusW-1:0]         status_o,
  output logic [pida_pkg::CountW-1:0]          count_after_o,
  output logic signed [pida_pkg::ValueW-1:0]   read_value_o
);
  import pida_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // compare width covers both the count and a position
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam logic [CmpW-1:0] CapW = CmpW'(CAPACITY);

  logic [ValueW-1:0] cells_q [CAPACITY];
  logic [ValueW-1:0] cells_d [CAPACITY];
  logic [CntW-1:0]   count_q, count_d;

  logic [StatusW-1:0] status_q, status_d;
  logic [CountW-1:0]  count_out_q;
  logic [ValueW-1:0]  read_q, read_d;

  logic [CmpW-1:0] cnt_w, pos_w, idx_w, cnt_new;
  logic            do_ins, do_del;

  assign cnt_w = CmpW'(count_q);
  assign pos_w = CmpW'(position_i);

  // decode the request
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    idx_w    = '0;
    status_d = ST_BADPOS;
    read_d   = '0;
    unique case (req_type_i)
      REQ_INSERT: begin
        if (cnt_w >= CapW) begin
          status_d = ST_FULL;
        end else if (place_i == PLACE_START) begin
          do_ins = 1'b1;
        end else if (place_i == PLACE_END) begin
          do_ins = 1'b1;
          idx_w  = cnt_w;
        end else if (place_i == PLACE_POS && pos_w != '0 && pos_w <= cnt_w + 1'b1) begin
          do_ins = 1'b1;
          idx_w  = pos_w - 1'b1;
        end
      end
      REQ_DELETE: begin
        if (cnt_w == '0) begin
          status_d = ST_EMPTY;
        end else if (place_i == PLACE_START) begin
          do_del = 1'b1;
        end else if (place_i == PLACE_END) begin
          do_del = 1'b1;
          idx_w  = cnt_w - 1'b1;
        end else if (place_i == PLACE_POS && pos_w != '0 && pos_w <= cnt_w) begin
          do_del = 1'b1;
          idx_w  = pos_w - 1'b1;
        end
      end
      REQ_READ: begin
        if (cnt_w == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_w != '0 && pos_w <= cnt_w) begin
          status_d = ST_OK;
          idx_w    = pos_w - 1'b1;
          read_d   = cells_q[idx_w[IdxW-1:0]];
        end
      end
      default: status_d = ST_BADPOS;
    endcase
    if (do_ins || do_del) status_d = ST_OK;
  end

  // each cell keeps its value, takes a neighbor's or takes the new value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_d[i] = cells_q[i];
      if (do_ins) begin
        if (CmpW'(i) == idx_w) begin
          cells_d[i] = value_i;
        end else if (i > 0 && CmpW'(i) > idx_w && CmpW'(i) <= cnt_w) begin
          cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (i + 1 < CAPACITY && CmpW'(i) >= idx_w && CmpW'(i + 1) < cnt_w) begin
          cells_d[i] = cells_q[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + 1'b1;
    else if (do_del) count_d = count_q - 1'b1;
  end

  assign cnt_new = CmpW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cells_q     <= cells_d;
      status_q    <= status_d;
      count_out_q <= cnt_new[CountW-1:0];
      read_q      <= read_d;
    end
  end

  assign status_o      = status_q;
  assign count_after_o = count_out_q;
  assign read_value_o  = read_q;

endmodule
